### src/ifmt_pkg.sv
// Shared types, codes and helpers for the integer field formatter.
package ifmt_pkg;

    localparam int CNT_W = 7;
    localparam int NDIG  = 24;
    localparam int DIG_W = 4;

    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_OCT  = 3'd2;
    localparam logic [2:0] CMD_HEXL = 3'd3;
    localparam logic [2:0] CMD_HEXU = 3'd4;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef logic [NDIG-1:0][DIG_W-1:0] digits_t;

    typedef struct packed {
        digits_t          digs;
        logic [4:0]       len;
        logic [1:0]       plen;
        logic [7:0]       pre_first;
        logic [7:0]       pre_last;
        logic [CNT_W-1:0] zeros;
        logic [CNT_W-1:0] spaces;
        logic             left;
        logic             upper;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_LEN,
        F_PLAN
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LEAD,
        B_PREFIX,
        B_ZERO,
        B_DIGIT,
        B_TRAIL
    } back_state_t;

    function automatic logic [7:0] digit_char(logic [DIG_W-1:0] d, logic upper);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'b0, d};
        end
        else
        begin
            c = (upper ? CH_A_UP : CH_A_LO) + {4'b0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

### src/integer_field_formatter.sv
// Top level of the printf-style integer field formatter.
//
// Input side is a queue write port: an item (command, value, size_code,
// field_width, precision and the four flags) is taken on a clock edge
// with push high and full low. Result side is a queue read port: while
// empty is low, character and last show the oldest waiting beat, which
// leaves on an edge with pop high. last marks the final character of a
// field. An item with a command code above upper hex is dropped silently.
// The front converts the operand: decimal by one double-dabble step per
// operand bit (8, 16, 32 or 64), octal and hex as plain bit groups; then
// it finds the digit count and plans the layout. A two-entry job queue
// lets the front work on the next item while the back streams the current
// field at one character per cycle while pop is high, after a load step
// in its idle state for each field, so the output serializer sets the
// rate for long fields and the decimal converter for short ones.
// When pop is held low, the back holds its beat and stops; the queue then
// fills and full stays high. Reset clears all control state; no field in
// flight survives it.
module integer_field_formatter #(
    parameter int MAX_FIELD = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [63:0] value,
    input  logic [1:0]  size_code,
    input  logic [6:0]  field_width,
    input  logic [5:0]  precision,
    input  logic        left_align,
    input  logic        zero_pad,
    input  logic        plus_sign,
    input  logic        alt_prefix,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  character,
    output logic        last
);

    ifmt_pkg::job_t wr_job;
    ifmt_pkg::job_t rd_job;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;

    ifmt_front #(
        .MAX_FIELD(MAX_FIELD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .value      (value),
        .size_code  (size_code),
        .field_width(field_width),
        .precision  (precision),
        .left_align (left_align),
        .zero_pad   (zero_pad),
        .plus_sign  (plus_sign),
        .alt_prefix (alt_prefix),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (wr_job)
    );

    ifmt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data(wr_job),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_data(rd_job),
        .empty  (q_empty)
    );

    ifmt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (rd_job),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .character(character),
        .last     (last)
    );

endmodule

### src/ifmt_front.sv
// Front part: accepts items, extracts digits and plans the field layout.
module ifmt_front #(
    parameter int MAX_FIELD = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           command,
    input  logic [63:0]          value,
    input  logic [1:0]           size_code,
    input  logic [6:0]           field_width,
    input  logic [5:0]           precision,
    input  logic                 left_align,
    input  logic                 zero_pad,
    input  logic                 plus_sign,
    input  logic                 alt_prefix,
    input  logic                 q_full,
    output logic                 q_push,
    output ifmt_pkg::job_t       q_data
);

    localparam int CW   = ifmt_pkg::CNT_W;
    localparam int ND   = ifmt_pkg::NDIG;
    localparam int DW   = ifmt_pkg::NDIG * ifmt_pkg::DIG_W;
    localparam logic [CW-1:0] MAX_W = CW'(MAX_FIELD);

    ifmt_pkg::front_state_t state_reg, state_next;

    logic [2:0]          cmd_reg;
    logic [63:0]         mag_reg;
    logic [63:0]         sh_reg;
    logic                neg_reg;
    logic                nz_reg;
    logic [6:0]          width_reg;
    logic [5:0]          prec_reg;
    logic                left_reg;
    logic                zfill_reg;
    logic                plus_reg;
    logic                alt_reg;
    logic [6:0]          bit_cnt_reg;
    ifmt_pkg::digits_t   digs_reg;
    logic [4:0]          len_reg;

    logic [63:0]         mask;
    logic                sgn;
    logic [63:0]         raw;
    logic                in_neg;
    logic [63:0]         in_mag;
    logic [6:0]          in_bits;
    logic [63:0]         in_sh;
    logic                cmd_ok;
    logic                accept;
    logic                is_dec;

    ifmt_pkg::digits_t   adj;
    logic [DW-1:0]       adj_flat;
    ifmt_pkg::digits_t   dabble_next;
    ifmt_pkg::digits_t   direct_digs;
    logic [71:0]         mag72;
    logic [95:0]         mag96;
    logic [4:0]          len_calc;

    logic [1:0]          plen;
    logic [7:0]          pre_first;
    logic [7:0]          pre_last;
    logic [CW-1:0]       w_clamp;
    logic [CW-1:0]       lim;
    logic [CW-1:0]       prec_eff;
    logic [CW-1:0]       len_ext;
    logic [CW-1:0]       zeros;
    logic [CW-1:0]       core;
    logic [CW-1:0]       fill;
    logic [CW-1:0]       spaces;

    // Operand cut and sign handling
    always_comb
    begin
        case (size_code)
            ifmt_pkg::SZ_8:
            begin
                mask    = 64'h0000_0000_0000_00FF;
                sgn     = value[7];
                in_bits = 7'd8;
            end
            ifmt_pkg::SZ_16:
            begin
                mask    = 64'h0000_0000_0000_FFFF;
                sgn     = value[15];
                in_bits = 7'd16;
            end
            ifmt_pkg::SZ_32:
            begin
                mask    = 64'h0000_0000_FFFF_FFFF;
                sgn     = value[31];
                in_bits = 7'd32;
            end
            default:
            begin
                mask    = 64'hFFFF_FFFF_FFFF_FFFF;
                sgn     = value[63];
                in_bits = 7'd64;
            end
        endcase
        raw    = value & mask;
        in_neg = (command == ifmt_pkg::CMD_SDEC) && sgn;
        in_mag = in_neg ? ((~raw + 64'd1) & mask) : raw;
        case (size_code)
            ifmt_pkg::SZ_8:  in_sh = in_mag << 56;
            ifmt_pkg::SZ_16: in_sh = in_mag << 48;
            ifmt_pkg::SZ_32: in_sh = in_mag << 32;
            default:         in_sh = in_mag;
        endcase
        cmd_ok = command <= ifmt_pkg::CMD_HEXU;
    end

    assign accept = push && !full;
    assign is_dec = cmd_reg inside {ifmt_pkg::CMD_SDEC, ifmt_pkg::CMD_UDEC};

    // One double-dabble step per cycle for decimal
    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            adj[i] = (digs_reg[i] >= 4'd5) ? digs_reg[i] + 4'd3 : digs_reg[i];
        end
        adj_flat    = adj;
        dabble_next = {adj_flat[DW-2:0], sh_reg[63]};
    end

    // Octal and hex digits are plain bit groups
    always_comb
    begin
        mag72 = {8'b0, mag_reg};
        mag96 = {32'b0, mag_reg};
        for (int i = 0; i < ND; i++)
        begin
            if (cmd_reg == ifmt_pkg::CMD_OCT)
            begin
                direct_digs[i] = {1'b0, mag72[3*i +: 3]};
            end
            else
            begin
                direct_digs[i] = mag96[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        len_calc = 5'd1;
        for (int i = 0; i < ND; i++)
        begin
            if (digs_reg[i] != 4'd0)
            begin
                len_calc = 5'(i + 1);
            end
        end
    end

    // Field layout
    always_comb
    begin
        plen      = 2'd0;
        pre_first = ifmt_pkg::CH_ZERO;
        pre_last  = ifmt_pkg::CH_ZERO;
        case (cmd_reg)
            ifmt_pkg::CMD_SDEC:
            begin
                if (neg_reg)
                begin
                    plen     = 2'd1;
                    pre_last = ifmt_pkg::CH_MINUS;
                end
                else if (plus_reg)
                begin
                    plen     = 2'd1;
                    pre_last = ifmt_pkg::CH_PLUS;
                end
            end
            ifmt_pkg::CMD_OCT:
            begin
                if (alt_reg && nz_reg)
                begin
                    plen = 2'd1;
                end
            end
            ifmt_pkg::CMD_HEXL, ifmt_pkg::CMD_HEXU:
            begin
                if (alt_reg && nz_reg)
                begin
                    plen     = 2'd2;
                    pre_last = (cmd_reg == ifmt_pkg::CMD_HEXU) ? ifmt_pkg::CH_X_UP
                                                                : ifmt_pkg::CH_X_LO;
                end
            end
            default:
            begin
                plen = 2'd0;
            end
        endcase

        w_clamp  = (CW'(width_reg) > MAX_W) ? MAX_W : CW'(width_reg);
        lim      = MAX_W - CW'(plen);
        prec_eff = (CW'(prec_reg) > lim) ? lim : CW'(prec_reg);
        len_ext  = CW'(len_reg);
        zeros    = (prec_eff > len_ext) ? prec_eff - len_ext : '0;
        if ((cmd_reg == ifmt_pkg::CMD_OCT) && (zeros != '0))
        begin
            plen = 2'd0;
        end
        core = CW'(plen) + zeros + len_ext;
        fill = (w_clamp > core) ? w_clamp - core : '0;
        if ((prec_reg == 6'd0) && zfill_reg && !left_reg)
        begin
            zeros  = zeros + fill;
            spaces = '0;
        end
        else
        begin
            spaces = fill;
        end

        q_data.digs      = digs_reg;
        q_data.len       = len_reg;
        q_data.plen      = plen;
        q_data.pre_first = pre_first;
        q_data.pre_last  = pre_last;
        q_data.zeros     = zeros;
        q_data.spaces    = spaces;
        q_data.left      = left_reg;
        q_data.upper     = (cmd_reg == ifmt_pkg::CMD_HEXU);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ifmt_pkg::F_IDLE:
            begin
                if (push && cmd_ok)
                begin
                    state_next = ifmt_pkg::F_CONV;
                end
            end
            ifmt_pkg::F_CONV:
            begin
                if (!is_dec || (bit_cnt_reg == 7'd1))
                begin
                    state_next = ifmt_pkg::F_LEN;
                end
            end
            ifmt_pkg::F_LEN:
            begin
                state_next = ifmt_pkg::F_PLAN;
            end
            ifmt_pkg::F_PLAN:
            begin
                if (!q_full)
                begin
                    state_next = ifmt_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = ifmt_pkg::F_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        full   = (state_reg != ifmt_pkg::F_IDLE);
        q_push = (state_reg == ifmt_pkg::F_PLAN) && !q_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ifmt_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ifmt_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg     <= command;
                    mag_reg     <= in_mag;
                    sh_reg      <= in_sh;
                    neg_reg     <= in_neg;
                    nz_reg      <= (raw != 64'd0);
                    width_reg   <= field_width;
                    prec_reg    <= precision;
                    left_reg    <= left_align;
                    zfill_reg   <= zero_pad;
                    plus_reg    <= plus_sign;
                    alt_reg     <= alt_prefix;
                    bit_cnt_reg <= in_bits;
                    digs_reg    <= '0;
                end
            end
            ifmt_pkg::F_CONV:
            begin
                if (is_dec)
                begin
                    digs_reg    <= dabble_next;
                    sh_reg      <= {sh_reg[62:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - 7'd1;
                end
                else
                begin
                    digs_reg <= direct_digs;
                end
            end
            ifmt_pkg::F_LEN:
            begin
                len_reg <= len_calc;
            end
            default:
            begin
                len_reg <= len_reg;
            end
        endcase
    end

endmodule

### src/ifmt_queue.sv
// Two-entry job queue between the front and back parts.
module ifmt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  ifmt_pkg::job_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output ifmt_pkg::job_t rd_data,
    output logic           empty
);

    ifmt_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           do_wr;
    logic           do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/ifmt_back.sv
// Back part: walks a planned field and sends one character per beat.
module ifmt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  ifmt_pkg::job_t q_data,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     character,
    output logic           last
);

    localparam int CW = ifmt_pkg::CNT_W;

    ifmt_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    ifmt_pkg::job_t        job_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_char_reg;
    logic                  out_last_reg;

    ifmt_pkg::job_t        src;
    ifmt_pkg::back_state_t after_digit;
    ifmt_pkg::back_state_t after_prefix;
    ifmt_pkg::back_state_t after_lead;
    ifmt_pkg::back_state_t from_idle;
    ifmt_pkg::back_state_t follow;
    logic                  advance;
    logic                  emit;
    logic [7:0]            ch;
    logic                  ch_last;
    logic [4:0]            idx;

    function automatic logic [CW-1:0] count_of(ifmt_pkg::back_state_t s, ifmt_pkg::job_t j);
        logic [CW-1:0] c;
        case (s)
            ifmt_pkg::B_LEAD, ifmt_pkg::B_TRAIL: c = j.spaces;
            ifmt_pkg::B_PREFIX:                  c = CW'(j.plen);
            ifmt_pkg::B_ZERO:                    c = j.zeros;
            ifmt_pkg::B_DIGIT:                   c = CW'(j.len);
            default:                             c = '0;
        endcase
        return c;
    endfunction

    assign advance = !out_valid_reg || pop;
    assign src     = (state_reg == ifmt_pkg::B_IDLE) ? q_data : job_reg;

    always_comb
    begin
        after_digit  = (src.left && (src.spaces != '0)) ? ifmt_pkg::B_TRAIL
                                                        : ifmt_pkg::B_IDLE;
        after_prefix = (src.zeros != '0) ? ifmt_pkg::B_ZERO : ifmt_pkg::B_DIGIT;
        after_lead   = (src.plen != 2'd0) ? ifmt_pkg::B_PREFIX : after_prefix;
        from_idle    = (!src.left && (src.spaces != '0)) ? ifmt_pkg::B_LEAD : after_lead;
        case (state_reg)
            ifmt_pkg::B_IDLE:   follow = from_idle;
            ifmt_pkg::B_LEAD:   follow = after_lead;
            ifmt_pkg::B_PREFIX: follow = after_prefix;
            ifmt_pkg::B_ZERO:   follow = ifmt_pkg::B_DIGIT;
            ifmt_pkg::B_DIGIT:  follow = after_digit;
            default:            follow = ifmt_pkg::B_IDLE;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ifmt_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = follow;
                    cnt_next   = count_of(follow, src);
                end
            end
            default:
            begin
                if (advance)
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = follow;
                        cnt_next   = count_of(follow, src);
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        q_pop   = (state_reg == ifmt_pkg::B_IDLE) && !q_empty;
        emit    = (state_reg != ifmt_pkg::B_IDLE);
        idx     = 5'(cnt_reg - CW'(1));
        ch_last = (cnt_reg == CW'(1)) && (follow == ifmt_pkg::B_IDLE);
        case (state_reg)
            ifmt_pkg::B_PREFIX:
            begin
                ch = (cnt_reg == CW'(1)) ? job_reg.pre_last : job_reg.pre_first;
            end
            ifmt_pkg::B_ZERO:
            begin
                ch = ifmt_pkg::CH_ZERO;
            end
            ifmt_pkg::B_DIGIT:
            begin
                ch = ifmt_pkg::digit_char(job_reg.digs[idx], job_reg.upper);
            end
            default:
            begin
                ch = ifmt_pkg::CH_SPACE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ifmt_pkg::B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (advance)
        begin
            out_char_reg <= ch;
            out_last_reg <= ch_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign character = out_char_reg;
    assign last      = out_last_reg;

endmodule

### src/ifmt_checker.sv
// Port-level checks for the integer field formatter, bound to the top level.
module ifmt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic [2:0] command,
    input logic       empty,
    input logic       pop,
    input logic [7:0] character,
    input logic       last
);

    logic [15:0] acc_cnt_reg;
    logic [15:0] done_cnt_reg;
    logic        item_in;
    logic        field_out;

    assign item_in   = push && !full && (command <= ifmt_pkg::CMD_HEXU);
    assign field_out = pop && !empty && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg  <= '0;
            done_cnt_reg <= '0;
        end
        else
        begin
            if (item_in)
            begin
                acc_cnt_reg <= acc_cnt_reg + 16'd1;
            end
            if (field_out)
            begin
                done_cnt_reg <= done_cnt_reg + 16'd1;
            end
        end
    end

    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(character) && $stable(last))
        else $error("waiting beat changed before pop");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (character == ifmt_pkg::CH_SPACE) || (character == ifmt_pkg::CH_PLUS)
            || (character == ifmt_pkg::CH_MINUS) || (character == ifmt_pkg::CH_X_LO)
            || (character == ifmt_pkg::CH_X_UP)
            || ((character >= ifmt_pkg::CH_ZERO) && (character <= ifmt_pkg::CH_NINE))
            || ((character >= ifmt_pkg::CH_A_LO) && (character <= ifmt_pkg::CH_F_LO))
            || ((character >= ifmt_pkg::CH_A_UP) && (character <= ifmt_pkg::CH_F_UP)))
        else $error("character outside the field alphabet");

    a_no_extra_field: assert property (@(posedge clk) disable iff (!rst_n)
        field_out |-> (done_cnt_reg != acc_cnt_reg))
        else $error("field finished with no item pending");

    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty && !full)
        else $error("ports not idle after reset");

endmodule

bind integer_field_formatter ifmt_checker u_ifmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .command  (command),
    .empty    (empty),
    .pop      (pop),
    .character(character),
    .last     (last)
);

### test/testbench.sv
// Testbench for integer_field_formatter: queue-style driver and monitor, field predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FIELD = 64;

    localparam logic [2:0] CMD_SDEC = ifmt_pkg::CMD_SDEC;
    localparam logic [2:0] CMD_UDEC = ifmt_pkg::CMD_UDEC;
    localparam logic [2:0] CMD_OCT  = ifmt_pkg::CMD_OCT;
    localparam logic [2:0] CMD_HEXL = ifmt_pkg::CMD_HEXL;
    localparam logic [2:0] CMD_HEXU = ifmt_pkg::CMD_HEXU;

    localparam logic [1:0] SZ_8  = ifmt_pkg::SZ_8;
    localparam logic [1:0] SZ_16 = ifmt_pkg::SZ_16;
    localparam logic [1:0] SZ_32 = ifmt_pkg::SZ_32;
    localparam logic [1:0] SZ_64 = ifmt_pkg::SZ_64;

    localparam logic [7:0] CH_SPACE = ifmt_pkg::CH_SPACE;
    localparam logic [7:0] CH_PLUS  = ifmt_pkg::CH_PLUS;
    localparam logic [7:0] CH_MINUS = ifmt_pkg::CH_MINUS;
    localparam logic [7:0] CH_ZERO  = ifmt_pkg::CH_ZERO;
    localparam logic [7:0] CH_A_UP  = ifmt_pkg::CH_A_UP;
    localparam logic [7:0] CH_X_UP  = ifmt_pkg::CH_X_UP;
    localparam logic [7:0] CH_A_LO  = ifmt_pkg::CH_A_LO;
    localparam logic [7:0] CH_X_LO  = ifmt_pkg::CH_X_LO;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] value;
        logic [1:0]  size_code;
        logic [6:0]  field_width;
        logic [5:0]  precision;
        logic        left_align;
        logic        zero_pad;
        logic        plus_sign;
        logic        alt_prefix;
    } item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    item_t      drv = '0;
    logic       full;
    logic       empty;
    logic [7:0] character;
    logic       last;

    item_t       queued_items[$];
    char_beat_t  pending_chars[$];
    char_beat_t  want;
    int          mismatches = 0;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;

    integer_field_formatter #(.MAX_FIELD(MAX_FIELD)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .command(drv.command),
        .value(drv.value),
        .size_code(drv.size_code),
        .field_width(drv.field_width),
        .precision(drv.precision),
        .left_align(drv.left_align),
        .zero_pad(drv.zero_pad),
        .plus_sign(drv.plus_sign),
        .alt_prefix(drv.alt_prefix),
        .empty(empty),
        .pop(pop),
        .character(character),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // Format one integer field and queue the characters it should produce.
    function automatic void format_field(input item_t it);
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic [63:0] v;
        logic [3:0]  d;
        logic        neg;
        logic [7:0]  dig[24];
        logic [7:0]  pre[2];
        logic [7:0]  line[$];
        int unsigned bits, base, len, plen, prec, zeros, spaces, core, width, n;
        int          i;
        if (it.command > CMD_HEXU)
        begin
            return;
        end
        bits = 8 << it.size_code;
        mask = (it.size_code == SZ_64) ? '1 : ((64'd1 << bits) - 64'd1);
        raw = it.value & mask;
        mag = raw;
        neg = 1'b0;
        if (it.command == CMD_SDEC && raw[bits-1])
        begin
            neg = 1'b1;
            mag = (64'd0 - raw) & mask;
        end
        base = (it.command <= CMD_UDEC) ? 10 : ((it.command == CMD_OCT) ? 8 : 16);
        len = 0;
        v = mag;
        do
        begin
            d = 4'(v % base);
            if (d < 4'd10)
            begin
                dig[len] = CH_ZERO + 8'(d);
            end
            else
            begin
                dig[len] = ((it.command == CMD_HEXU) ? CH_A_UP : CH_A_LO) + 8'(d - 4'd10);
            end
            v = v / base;
            len++;
        end
        while (v != 0 && len < 24);

        plen = 0;
        case (it.command)
            CMD_SDEC:
            begin
                if (neg)
                begin
                    pre[0] = CH_MINUS;
                    plen = 1;
                end
                else if (it.plus_sign)
                begin
                    pre[0] = CH_PLUS;
                    plen = 1;
                end
            end
            CMD_OCT:
            begin
                if (it.alt_prefix && mag != 0)
                begin
                    pre[0] = CH_ZERO;
                    plen = 1;
                end
            end
            CMD_HEXL, CMD_HEXU:
            begin
                if (it.alt_prefix && mag != 0)
                begin
                    pre[0] = CH_ZERO;
                    pre[1] = (it.command == CMD_HEXU) ? CH_X_UP : CH_X_LO;
                    plen = 2;
                end
            end
            default:
            begin
            end
        endcase

        width = (it.field_width > MAX_FIELD) ? MAX_FIELD : it.field_width;
        prec = it.precision;
        if (prec > MAX_FIELD - plen)
        begin
            prec = MAX_FIELD - plen;
        end
        zeros = (prec > len) ? prec - len : 0;
        // a zero from the precision already serves as the octal prefix
        if (it.command == CMD_OCT && zeros > 0)
        begin
            plen = 0;
        end
        core = plen + zeros + len;
        spaces = 0;
        if (it.precision == 0 && it.zero_pad && !it.left_align)
        begin
            if (width > core)
            begin
                zeros += width - core;
            end
        end
        else if (width > core)
        begin
            spaces = width - core;
        end

        if (!it.left_align)
        begin
            repeat (spaces) line.push_back(CH_SPACE);
        end
        for (i = 0; i < plen; i++)
        begin
            line.push_back(pre[i]);
        end
        repeat (zeros) line.push_back(CH_ZERO);
        for (i = len; i > 0; i--)
        begin
            line.push_back(dig[i-1]);
        end
        if (it.left_align)
        begin
            repeat (spaces) line.push_back(CH_SPACE);
        end

        n = (line.size() > MAX_FIELD) ? MAX_FIELD : line.size();
        for (i = 0; i < n; i++)
        begin
            pending_chars.push_back('{ch: line[i], last: (i == n - 1)});
        end
    endfunction

    function automatic void add_item(logic [2:0] cmd, logic [63:0] val, logic [1:0] sz,
                                     logic [6:0] w, logic [5:0] p, logic la, logic zp,
                                     logic ps, logic ap);
        item_t it;
        it.command = cmd;
        it.value = val;
        it.size_code = sz;
        it.field_width = w;
        it.precision = p;
        it.left_align = la;
        it.zero_pad = zp;
        it.plus_sign = ps;
        it.alt_prefix = ap;
        queued_items.push_back(it);
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        int unsigned bits;
        pick = $urandom_range(15);
        it.command = (pick == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        it.size_code = 2'($urandom_range(3));
        bits = 8 << it.size_code;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3: it.value = {$urandom, $urandom};
            4, 5:       it.value = 64'($urandom_range(30));
            6:          it.value = '0;
            7:          it.value = '1;
            8:          it.value = 64'd1 << (bits - 1);
            default:    it.value = {$urandom, $urandom} | (64'd1 << (bits - 1));
        endcase
        pick = $urandom_range(19);
        if (pick < 8)
        begin
            it.field_width = 7'($urandom_range(24));
        end
        else if (pick < 14)
        begin
            it.field_width = '0;
        end
        else
        begin
            it.field_width = 7'($urandom_range(127));
        end
        pick = $urandom_range(19);
        if (pick < 9)
        begin
            it.precision = '0;
        end
        else if (pick < 16)
        begin
            it.precision = 6'($urandom_range(24, 1));
        end
        else
        begin
            it.precision = 6'($urandom_range(63));
        end
        it.left_align = 1'($urandom_range(1));
        it.zero_pad = 1'($urandom_range(1));
        it.plus_sign = 1'($urandom_range(1));
        it.alt_prefix = 1'($urandom_range(1));
        return it;
    endfunction

    // driver: hold each beat until accepted, then advance to the next queued item
    always @(posedge clk)
    begin
        logic next_push;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            next_push = push;
            if (push && !full)
            begin
                format_field(drv);
                next_push = 1'b0;
            end
            if (!next_push && queued_items.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                drv <= queued_items.pop_front();
                next_push = 1'b1;
            end
            push <= next_push;
        end
    end

    // monitor: check each popped beat against the oldest predicted character
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_chars.size() == 0)
                begin
                    flag_error($sformatf("unexpected beat char=%h last=%b", character, last));
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (character !== want.ch || last !== want.last)
                    begin
                        flag_error($sformatf("char exp=%h act=%h, last exp=%b act=%b",
                                             want.ch, character, want.last, last));
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int phase;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 7;
                    recv_idle = 84;
                end
                1:
                begin
                    send_idle = 84;
                    recv_idle = 7;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (phase == 0)
            begin
                add_item(CMD_SDEC, 64'h80, SZ_8, 0, 0, 0, 0, 0, 0);
                add_item(CMD_SDEC, 64'h8000_0000_0000_0000, SZ_64, 0, 0, 0, 0, 1, 0);
                add_item(CMD_UDEC, '1, SZ_64, 0, 0, 0, 0, 0, 0);
                add_item(CMD_SDEC, 64'd42, SZ_32, 10, 0, 0, 1, 1, 0);
                add_item(CMD_SDEC, 64'hFFFB, SZ_16, 8, 4, 0, 1, 0, 0);
                add_item(CMD_UDEC, 64'd12345, SZ_32, 8, 3, 0, 0, 0, 0);
                add_item(CMD_SDEC, 64'hFFFF_FFD6, SZ_32, 10, 0, 1, 1, 1, 0);
                add_item(CMD_OCT, 64'd0, SZ_32, 0, 0, 0, 0, 0, 1);
                add_item(CMD_OCT, 64'd8, SZ_32, 0, 0, 0, 0, 0, 1);
                add_item(CMD_OCT, 64'd8, SZ_32, 7, 5, 0, 0, 0, 1);
                add_item(CMD_HEXL, 64'd0, SZ_32, 6, 0, 0, 0, 0, 1);
                add_item(CMD_HEXL, 64'hDEAD_BEEF, SZ_64, 16, 0, 0, 1, 0, 1);
                add_item(CMD_HEXU, 64'hABCD, SZ_16, 14, 8, 1, 0, 0, 1);
                add_item(CMD_UDEC, 64'd5, SZ_8, 4, 0, 0, 0, 1, 1);
                add_item(CMD_SDEC, 64'd1, SZ_8, 127, 0, 0, 0, 0, 0);
                add_item(CMD_HEXL, 64'hFF, SZ_8, 0, 63, 0, 0, 0, 1);
                add_item(CMD_SDEC, 64'h8000, SZ_16, 0, 63, 0, 0, 0, 0);
                add_item(3'd5, 64'd7, SZ_8, 4, 0, 0, 0, 0, 0);
                add_item(3'd6, '1, SZ_64, 64, 63, 1, 1, 1, 1);
                add_item(3'd7, 64'd0, SZ_32, 0, 0, 0, 0, 0, 0);
                add_item(CMD_OCT, '1, SZ_64, 0, 0, 0, 0, 0, 1);
                add_item(CMD_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, SZ_64, 64, 0, 0, 1, 1, 0);
                add_item(CMD_UDEC, 64'hFFFF_FFFF_FFFF_FF12, SZ_8, 0, 0, 0, 0, 0, 0);
                add_item(CMD_HEXU, 64'h1234_5678_9ABC_DEF0, SZ_64, 64, 0, 1, 0, 0, 1);
            end
            repeat ((phase == 2) ? 76 : 60) queued_items.push_back(random_item());
            // hold the sender until every predicted character has been popped
            while (queued_items.size() != 0 || push || pending_chars.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (150) @(negedge clk);
        end
        if (mismatches == 0 && pending_chars.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
